// ===== hw/rtl/lsc_pkg.sv =====
// Package for the latency statistics collector: sizes, codes, the class record
// type and helper functions. No dependencies.
package lsc_pkg;

  localparam int NUM_CLASSES = 16;
  localparam int COUNT_BITS  = 32;
  localparam int NUM_BINS    = 64;
  localparam int BIN_W       = 6;
  localparam int MAX_BIN     = 63;
  localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int HIST_AW     = CLS_W + BIN_W;
  localparam int HIST_DEPTH  = NUM_CLASSES * NUM_BINS;

  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ACT_RECORD = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_IDLE   = 2'd3
  } action_t;

  localparam logic [1:0] OUT_SUCCESS = 2'd0;
  localparam logic [1:0] OUT_TIMEOUT = 2'd1;

  // One class entry of the statistics memory
  typedef struct packed {
    count_t      req;
    count_t      suc;
    count_t      err;
    count_t      tmo;
    logic [63:0] sum;
    logic [63:0] dmin;
    logic [63:0] dmax;
  } class_rec_t;

  localparam class_rec_t CLASS_RESET = '{req: '0, suc: '0, err: '0, tmo: '0,
                                         sum: '0, dmin: '1, dmax: '0};

  function automatic count_t sat_inc(input count_t v);
    return (v == COUNT_MAX) ? v : count_t'(v + 1'b1);
  endfunction

  // Low 32 bits of a counter, zero extended when the counter is narrower
  function automatic logic [31:0] cnt32(input count_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  // floor(log2 d), with 0 and 1 in bin 0
  function automatic logic [BIN_W-1:0] log2_bin(input logic [63:0] d);
    logic [BIN_W-1:0] b;
    b = '0;
    for (int i = 1; i < 64; i++) begin
      if (d[i]) b = BIN_W'(i);
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/latency_stats_collector.sv =====
// Latency statistics collector top level: class memory, histogram memory and
// the read-modify-write sequencer. Depends on lsc_pkg.
//
// Usage: one input channel (in_valid / in_stall) takes items with action,
// operation, outcome, duration and bin_select. In-range record items update one class
// and one histogram bin, read items return one class and one bin, clear items
// empty all statistics and bump the generation count. Action code three is
// swallowed without a result. Every other item yields one result on the
// output channel (out_valid / out_stall), held stable while stalled.
// Each item has two steps: the accept cycle issues registered reads of the class and
// histogram memories, then the modify state modifies, writes back and loads the
// output register. An item may follow at once.
// When the output register is still full, the write-back cycle waits.
// Back-to-back hits on one class need no forwarding: the write lands before
// the next read is issued.
// Reset and every clear start a clearing pass over the histogram memory,
// one entry a cycle over all HIST_DEPTH (1024) entries, with in_stall high; the
// class memory is cleared while the sweep covers its first NUM_CLASSES entries.
module latency_stats_collector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  operation,
  input  logic [1:0]  outcome,
  input  logic [63:0] duration,
  input  logic [5:0]  bin_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        rejected,
  output logic [31:0] request_total,
  output logic [31:0] success_total,
  output logic [31:0] error_total,
  output logic [31:0] timeout_total,
  output logic [63:0] duration_total,
  output logic [63:0] shortest,
  output logic [63:0] longest,
  output logic [5:0]  bin_index,
  output logic [31:0] bin_total,
  output logic [31:0] rejected_total,
  output logic [31:0] generation
);

  typedef enum logic [1:0] {ST_SWEEP, ST_IDLE, ST_MODIFY} state_t;

  state_t                       state;
  logic [lsc_pkg::HIST_AW-1:0]  sweep;
  lsc_pkg::count_t              rej_cnt;
  logic [31:0]                  gen_cnt;

  // Captured item
  lsc_pkg::action_t             act_q;
  logic [lsc_pkg::CLS_W-1:0]    cls_q;
  logic                         inrange_q;
  logic [1:0]                   outcome_q;
  logic [63:0]                  dur_q;
  logic [lsc_pkg::BIN_W-1:0]    sel_q;
  logic [lsc_pkg::BIN_W-1:0]    bin_q;

  // Memories
  lsc_pkg::class_rec_t          class_mem [lsc_pkg::NUM_CLASSES];
  lsc_pkg::count_t              hist_mem  [lsc_pkg::HIST_DEPTH];
  lsc_pkg::class_rec_t          class_rd;
  lsc_pkg::count_t              hist_rd;

  logic                         accept;
  logic                         out_free;
  logic                         inrange_in;
  logic [lsc_pkg::BIN_W-1:0]    bin_in;
  logic [lsc_pkg::CLS_W-1:0]    cls_rd_addr;
  logic [lsc_pkg::HIST_AW-1:0]  hist_rd_addr;
  logic                         upd_we;
  logic                         sweep_cls;
  logic                         sweep_last;
  lsc_pkg::class_rec_t          class_new;
  lsc_pkg::count_t              hist_new;
  lsc_pkg::count_t              rej_new;
  logic [64:0]                  sum_wide;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign inrange_in = {1'b0, operation} < 9'(lsc_pkg::NUM_CLASSES);
  assign bin_in     = (lsc_pkg::action_t'(action) == lsc_pkg::ACT_RECORD) ?
                      lsc_pkg::log2_bin(duration) : bin_select;

  // Read addresses: live input while idle, captured item afterwards
  always_comb begin
    if (state == ST_IDLE) begin
      cls_rd_addr = operation[lsc_pkg::CLS_W-1:0];
      hist_rd_addr = {operation[lsc_pkg::CLS_W-1:0], bin_in};
    end else begin
      cls_rd_addr = cls_q;
      hist_rd_addr = {cls_q, bin_q};
    end
  end

  // New class and bin values for a record item
  always_comb begin
    class_new = class_rd;
    class_new.req = lsc_pkg::sat_inc(class_rd.req);
    if (outcome_q == lsc_pkg::OUT_SUCCESS) class_new.suc = lsc_pkg::sat_inc(class_rd.suc);
    else class_new.err = lsc_pkg::sat_inc(class_rd.err);
    if (outcome_q == lsc_pkg::OUT_TIMEOUT) class_new.tmo = lsc_pkg::sat_inc(class_rd.tmo);
    sum_wide = {1'b0, class_rd.sum} + {1'b0, dur_q};
    class_new.sum = sum_wide[64] ? '1 : sum_wide[63:0];
    if (dur_q < class_rd.dmin) class_new.dmin = dur_q;
    if (dur_q > class_rd.dmax) class_new.dmax = dur_q;
    hist_new = lsc_pkg::sat_inc(hist_rd);
    rej_new = lsc_pkg::sat_inc(rej_cnt);
  end

  assign upd_we     = (state == ST_MODIFY) && out_free && inrange_q &&
                      (act_q == lsc_pkg::ACT_RECORD);
  assign sweep_cls  = {1'b0, sweep} < (lsc_pkg::HIST_AW + 1)'(lsc_pkg::NUM_CLASSES);
  assign sweep_last = sweep == lsc_pkg::HIST_AW'(lsc_pkg::HIST_DEPTH - 1);

  // Class memory
  always_ff @(posedge clk) begin
    if (state == ST_SWEEP && sweep_cls) begin
      class_mem[sweep[lsc_pkg::CLS_W-1:0]] <= lsc_pkg::CLASS_RESET;
    end else if (upd_we) begin
      class_mem[cls_q] <= class_new;
    end
    class_rd <= class_mem[cls_rd_addr];
  end

  // Histogram memory
  always_ff @(posedge clk) begin
    if (state == ST_SWEEP) begin
      hist_mem[sweep] <= '0;
    end else if (upd_we) begin
      hist_mem[{cls_q, bin_q}] <= hist_new;
    end
    hist_rd <= hist_mem[hist_rd_addr];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      sweep <= '0;
      rej_cnt <= '0;
      gen_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_SWEEP: begin
          sweep <= sweep + 1'b1;
          if (sweep_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            act_q <= lsc_pkg::action_t'(action);
            cls_q <= operation[lsc_pkg::CLS_W-1:0];
            inrange_q <= inrange_in;
            outcome_q <= outcome;
            dur_q <= duration;
            sel_q <= bin_select;
            bin_q <= bin_in;
            if (lsc_pkg::action_t'(action) != lsc_pkg::ACT_IDLE) state <= ST_MODIFY;
          end
        end
        ST_MODIFY: begin
          if (out_free) begin
            out_valid <= 1'b1;
            rejected <= 1'b0;
            request_total <= '0;
            success_total <= '0;
            error_total <= '0;
            timeout_total <= '0;
            duration_total <= '0;
            shortest <= '0;
            longest <= '0;
            bin_index <= '0;
            bin_total <= '0;
            rejected_total <= lsc_pkg::cnt32(rej_cnt);
            generation <= gen_cnt;
            state <= ST_IDLE;
            if (act_q == lsc_pkg::ACT_CLEAR) begin
              // empty everything and start the clearing pass
              rej_cnt <= '0;
              gen_cnt <= gen_cnt + 1'b1;
              generation <= gen_cnt + 1'b1;
              rejected_total <= '0;
              sweep <= '0;
              state <= ST_SWEEP;
            end else if (!inrange_q) begin
              rejected <= 1'b1;
              if (act_q == lsc_pkg::ACT_RECORD) begin
                rej_cnt <= rej_new;
                rejected_total <= lsc_pkg::cnt32(rej_new);
              end else begin
                bin_index <= sel_q;
              end
            end else if (act_q == lsc_pkg::ACT_RECORD) begin
              request_total <= lsc_pkg::cnt32(class_new.req);
              success_total <= lsc_pkg::cnt32(class_new.suc);
              error_total <= lsc_pkg::cnt32(class_new.err);
              timeout_total <= lsc_pkg::cnt32(class_new.tmo);
              duration_total <= class_new.sum;
              shortest <= class_new.dmin;
              longest <= class_new.dmax;
              bin_index <= bin_q;
              bin_total <= lsc_pkg::cnt32(hist_new);
            end else begin
              request_total <= lsc_pkg::cnt32(class_rd.req);
              success_total <= lsc_pkg::cnt32(class_rd.suc);
              error_total <= lsc_pkg::cnt32(class_rd.err);
              timeout_total <= lsc_pkg::cnt32(class_rd.tmo);
              duration_total <= class_rd.sum;
              shortest <= class_rd.dmin;
              longest <= class_rd.dmax;
              bin_index <= sel_q;
              bin_total <= lsc_pkg::cnt32(hist_rd);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lsc_checker.sv =====
// Port-level checks for the latency statistics collector, bound to the top
// level. Depends on latency_stats_collector's ports and lsc_pkg.
module lsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_stall,
  input logic        rejected,
  input logic [31:0] request_total,
  input logic [31:0] bin_total,
  input logic [31:0] generation
);

  // Clearing pass follows reset
  a_sweep_after_reset: assert property (@(posedge clk) $fell(rst) |-> in_stall)
    else $error("input not held off after reset");

  // One item at a time: busy in the cycle after an accepted item that yields a result
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action != lsc_pkg::ACT_IDLE) |=> in_stall)
    else $error("item accepted while previous item in progress");

  // A non-empty bin implies the class has seen requests
  a_bin_implies_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rejected && bin_total != 32'd0 |-> request_total != 32'd0)
    else $error("bin count without request count");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(generation) && $stable(request_total))
    else $error("stalled result changed");

endmodule

bind latency_stats_collector lsc_checker u_lsc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .action(action),
  .out_valid(out_valid), .out_stall(out_stall), .rejected(rejected),
  .request_total(request_total), .bin_total(bin_total), .generation(generation)
);

// ===== dv/latency_stats_collector_tb.sv =====
// Testbench for latency_stats_collector: random and directed record, read and clear items,
// checked against a behavioural model of the per-class statistics. Depends on lsc_pkg.
`timescale 1ns / 100ps

module latency_stats_collector_tb;

  typedef struct {
    logic [1:0]  act;
    logic [7:0]  op;
    logic [1:0]  oc;
    logic [63:0] dur;
    logic [5:0]  sel;
  } obs_t;

  typedef struct {
    logic        rej;
    logic [31:0] req, suc, err, tmo;
    logic [63:0] sum, dmin, dmax;
    logic [5:0]  bidx;
    logic [31:0] btot, rtot, gen;
  } stats_t;

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [1:0]  action = 0;
  logic [7:0]  operation = 0;
  logic [1:0]  outcome = 0;
  logic [63:0] duration = 0;
  logic [5:0]  bin_select = 0;
  logic        rejected;
  logic [31:0] request_total, success_total, error_total, timeout_total;
  logic [63:0] duration_total, shortest, longest;
  logic [5:0]  bin_index;
  logic [31:0] bin_total, rejected_total, generation;

  latency_stats_collector dut (.*);

  // model state
  logic [31:0] m_req [lsc_pkg::NUM_CLASSES], m_suc [lsc_pkg::NUM_CLASSES];
  logic [31:0] m_err [lsc_pkg::NUM_CLASSES], m_tmo [lsc_pkg::NUM_CLASSES];
  logic [63:0] m_sum [lsc_pkg::NUM_CLASSES], m_min [lsc_pkg::NUM_CLASSES];
  logic [63:0] m_max [lsc_pkg::NUM_CLASSES];
  logic [31:0] m_hist [lsc_pkg::NUM_CLASSES][lsc_pkg::NUM_BINS];
  logic [31:0] m_rej, m_gen;

  obs_t   pending_obs[$];
  stats_t expected_stats[$];
  int     sender_idle, receiver_idle, failures;
  bit     in_taken;

  initial forever #5 clk = ~clk;

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int bin_of(input logic [63:0] d);
    int b;
    b = 0;
    while (d > 1 && b < lsc_pkg::MAX_BIN) begin
      d = d >> 1;
      b++;
    end
    return b;
  endfunction

  task automatic empty_model();
    for (int c = 0; c < lsc_pkg::NUM_CLASSES; c++) begin
      m_req[c] = 0; m_suc[c] = 0; m_err[c] = 0; m_tmo[c] = 0;
      m_sum[c] = 0; m_min[c] = '1; m_max[c] = 0;
      for (int b = 0; b < lsc_pkg::NUM_BINS; b++) m_hist[c][b] = 0;
    end
    m_rej = 0;
  endtask

  // Advance the model by one accepted item and queue its result
  task automatic predict_stats(input obs_t o);
    stats_t r;
    int c, b;
    r = '{default: 0};
    if (o.act == lsc_pkg::ACT_IDLE) return;
    if (o.act == lsc_pkg::ACT_CLEAR) begin
      empty_model();
      m_gen++;
      r.gen = m_gen;
    end else if (o.op >= lsc_pkg::NUM_CLASSES) begin
      if (o.act == lsc_pkg::ACT_RECORD) m_rej = bump(m_rej);
      else r.bidx = o.sel;
      r.rej = 1; r.rtot = m_rej; r.gen = m_gen;
    end else begin
      c = int'(o.op);
      if (o.act == lsc_pkg::ACT_RECORD) begin
        m_req[c] = bump(m_req[c]);
        if (o.oc == lsc_pkg::OUT_SUCCESS) m_suc[c] = bump(m_suc[c]);
        else m_err[c] = bump(m_err[c]);
        if (o.oc == lsc_pkg::OUT_TIMEOUT) m_tmo[c] = bump(m_tmo[c]);
        m_sum[c] = ('1 - m_sum[c] < o.dur) ? '1 : m_sum[c] + o.dur;
        if (o.dur < m_min[c]) m_min[c] = o.dur;
        if (o.dur > m_max[c]) m_max[c] = o.dur;
        b = bin_of(o.dur);
        m_hist[c][b] = bump(m_hist[c][b]);
      end else begin
        b = int'(o.sel);
      end
      r.req = m_req[c]; r.suc = m_suc[c]; r.err = m_err[c]; r.tmo = m_tmo[c];
      r.sum = m_sum[c]; r.dmin = m_min[c]; r.dmax = m_max[c];
      r.bidx = 6'(b); r.btot = m_hist[c][b]; r.rtot = m_rej; r.gen = m_gen;
    end
    expected_stats.push_back(r);
  endtask

  function automatic obs_t mk(input int a, input int op, input int oc,
                              input logic [63:0] d, input int s);
    obs_t o;
    o.act = 2'(a); o.op = 8'(op); o.oc = 2'(oc); o.dur = d; o.sel = 6'(s);
    return o;
  endfunction

  function automatic logic [63:0] rand_dur();
    logic [63:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: d = 64'($urandom_range(0, 3));
      1: d = '1 - 64'($urandom_range(0, 2));
      default: d = d >> $urandom_range(0, 63);
    endcase
    return d;
  endfunction

  // Driver: present items at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (pending_obs.size() > 0 && $urandom_range(0, 99) >= sender_idle) begin
          obs_t o;
          o = pending_obs.pop_front();
          in_valid <= 1; action <= o.act; operation <= o.op;
          outcome <= o.oc; duration <= o.dur; bin_select <= o.sel;
        end else begin
          in_valid <= 0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle);
    end
  end

  // Monitor: model on input accept, compare on output accept
  always @(posedge clk) begin
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken)
      predict_stats(mk(action, operation, outcome, duration, bin_select));
    if (!rst && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result", $time);
        failures++;
      end else begin
        stats_t e;
        e = expected_stats.pop_front();
        if ({rejected, request_total, success_total, error_total, timeout_total,
             duration_total, shortest, longest, bin_index, bin_total,
             rejected_total, generation} !==
            {e.rej, e.req, e.suc, e.err, e.tmo, e.sum, e.dmin, e.dmax,
             e.bidx, e.btot, e.rtot, e.gen}) begin
          $display({"%0t: mismatch exp rej=%0d req=%0d suc=%0d err=%0d tmo=%0d",
                    " sum=%h min=%h max=%h bin=%0d bt=%0d rt=%0d gen=%0d"},
                   $time, e.rej, e.req, e.suc, e.err, e.tmo, e.sum, e.dmin, e.dmax,
                   e.bidx, e.btot, e.rtot, e.gen);
          $display({"%0t:          got rej=%0d req=%0d suc=%0d err=%0d tmo=%0d",
                    " sum=%h min=%h max=%h bin=%0d bt=%0d rt=%0d gen=%0d"},
                   $time, rejected, request_total, success_total, error_total,
                   timeout_total, duration_total, shortest, longest, bin_index,
                   bin_total, rejected_total, generation);
          failures++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_obs.size() > 0 || in_valid) @(posedge clk);
    while (expected_stats.size() > 0) @(posedge clk);
  endtask

  // Random phase: mostly in-range records, many reads, rare idle and clear items
  task automatic random_items(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        pending_obs.push_back(mk(lsc_pkg::ACT_RECORD, ($urandom_range(0, 9) == 0) ?
          $urandom_range(0, 255) : $urandom_range(0, lsc_pkg::NUM_CLASSES - 1),
          $urandom_range(0, 3), rand_dur(), $urandom));
      else if (r < 94)
        pending_obs.push_back(mk(lsc_pkg::ACT_READ, ($urandom_range(0, 9) == 0) ?
          $urandom_range(0, 255) : $urandom_range(0, lsc_pkg::NUM_CLASSES - 1),
          $urandom, rand_dur(), $urandom));
      else if (r < 97)
        pending_obs.push_back(mk(lsc_pkg::ACT_IDLE, $urandom, $urandom, rand_dur(),
                                 $urandom));
      else
        pending_obs.push_back(mk(lsc_pkg::ACT_CLEAR, $urandom, $urandom, rand_dur(),
                                 $urandom));
    end
  endtask

  initial begin
    empty_model();
    m_gen = 0;
    sender_idle = 7; receiver_idle = 69;
    repeat (3) @(posedge clk);
    rst <= 0;
    // directed: extremes, all outcomes, out-of-range, idle action, clear
    pending_obs.push_back(mk(lsc_pkg::ACT_READ, 0, 0, 0, 0));
    pending_obs.push_back(mk(lsc_pkg::ACT_RECORD, 0, 0, 0, 0));
    pending_obs.push_back(mk(lsc_pkg::ACT_RECORD, 0, 1, 1, 0));
    pending_obs.push_back(mk(lsc_pkg::ACT_RECORD, 0, 2, 64'd2, 0));
    pending_obs.push_back(mk(lsc_pkg::ACT_RECORD, 0, 3, '1, 63));
    pending_obs.push_back(mk(lsc_pkg::ACT_RECORD, 0, 0, '1, 0));
    pending_obs.push_back(mk(lsc_pkg::ACT_READ, 0, 3, 0, 63));
    pending_obs.push_back(mk(lsc_pkg::ACT_READ, 0, 0, 0, 0));
    pending_obs.push_back(mk(lsc_pkg::ACT_RECORD, lsc_pkg::NUM_CLASSES - 1, 1,
                             64'h8000_0000_0000_0000, 0));
    pending_obs.push_back(mk(lsc_pkg::ACT_RECORD, lsc_pkg::NUM_CLASSES, 0, 5, 0));
    pending_obs.push_back(mk(lsc_pkg::ACT_RECORD, 255, 3, '1, 63));
    pending_obs.push_back(mk(lsc_pkg::ACT_READ, 255, 0, 0, 42));
    pending_obs.push_back(mk(lsc_pkg::ACT_IDLE, 3, 1, 7, 1));
    pending_obs.push_back(mk(lsc_pkg::ACT_READ, lsc_pkg::NUM_CLASSES - 1, 0, 0, 63));
    pending_obs.push_back(mk(lsc_pkg::ACT_CLEAR, 0, 0, 0, 0));
    pending_obs.push_back(mk(lsc_pkg::ACT_READ, 0, 0, 0, 0));
    // hold off until every result is in
    drain();
    random_items(600);
    drain();
    sender_idle = 69; receiver_idle = 7;
    random_items(600);
    drain();
    sender_idle = 0; receiver_idle = 0;
    random_items(600);
    drain();
    repeat (50) @(posedge clk);
    if (failures == 0 && expected_stats.size() == 0)
      $display("latency_stats_collector_tb OK");
    else
      $display("latency_stats_collector_tb NOT OK");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("latency_stats_collector_tb NOT OK");
    $finish;
  end

endmodule

// ===== latency_stats_collector.f =====
hw/rtl/lsc_pkg.sv
hw/rtl/latency_stats_collector.sv
hw/rtl/lsc_checker.sv
dv/latency_stats_collector_tb.sv
